/* hw/rtl/bitmap_gap_allocator_assert.svh */
// Assertion macros shared by the RTL. The clock is clk and the reset is rst_n.
`ifndef BITMAP_GAP_ALLOCATOR_ASSERT_SVH
`define BITMAP_GAP_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BGA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bga_pkg.sv */
package bga_pkg;

  localparam int MAP_BITS_DEF = 1024;

  localparam int ACTION_W = 2;
  localparam int OFFSET_W = 10;
  localparam int COUNT_W  = 11;
  localparam int START_W  = 10;
  localparam int MAPB_W   = 8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam int BIT_W  = 11;
  localparam int BYTE_W = 8;

  typedef logic [BIT_W-1:0]  bit_idx_t;
  typedef logic [BYTE_W-1:0] byte_idx_t;

  localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MARK   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UNMARK = 2'd2;

  localparam logic REG_MAP_BYTES = 1'b0;

  localparam logic [MAPB_W-1:0] MAP_BYTES_RST = 8'd128;

endpackage

/* hw/rtl/bga_ram.sv */
module bga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/bitmap_gap_allocator.sv */
// Channel  Direction  Beat                              Handshake
// in       input      action, offset, count             in_valid / in_stall
// out      output     found, gap_start                  out_valid / out_stall
// cfg      input      map_bytes_in_use at address 0     APB, pready always high
//
// The map sits in a byte-wide RAM that is read one byte per cycle.
// A find reads the map bytes in order, up to the first fit or the last byte in use.
// A mark or unmark reads, changes and writes back each byte that the range touches.
// A beat that reads no byte goes from idle straight to the done state.
// After reset a clearing pass zeroes all (MAP_BITS+7)/8 map bytes and holds in_stall high.
// A finished result waits in the output register while the next beat is taken.
module bitmap_gap_allocator #(
  parameter int MAP_BITS = bga_pkg::MAP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bga_pkg::ACTION_W-1:0]    in_action,
  input  logic [bga_pkg::OFFSET_W-1:0]    in_offset,
  input  logic [bga_pkg::COUNT_W-1:0]     in_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_found,
  output logic [bga_pkg::START_W-1:0]     out_gap_start,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bga_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [bga_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [bga_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  import bga_pkg::*;

  localparam int MapBytes    = (MAP_BITS + 7) / 8;
  localparam int AddrW       = (MapBytes > 1) ? $clog2(MapBytes) : 1;
  localparam int BitCapInt   = (MAP_BITS > (2**BIT_W - 1)) ? (2**BIT_W - 1) : MAP_BITS;
  localparam int BytesCapInt = (MapBytes > (2**MAPB_W - 1)) ? (2**MAPB_W - 1) : MapBytes;
  localparam logic [BIT_W:0]      BitCap   = (BIT_W+1)'(BitCapInt);
  localparam logic [MAPB_W-1:0]   BytesCap = MAPB_W'(BytesCapInt);
  localparam logic [AddrW-1:0]    ClrLast  = AddrW'(MapBytes - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [AddrW-1:0]   clr_idx_r, clr_idx_nxt;
  logic [MAPB_W-1:0]  map_bytes_r;
  logic [ACTION_W-1:0] act_r, act_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  bit_idx_t           lo_r, lo_nxt;
  bit_idx_t           hi_r, hi_nxt;
  byte_idx_t          rd_idx_r, rd_idx_nxt;
  byte_idx_t          last_idx_r, last_idx_nxt;
  logic               rd_more_r, rd_more_nxt;
  logic               pipe_vld_r, pipe_vld_nxt;
  byte_idx_t          pipe_idx_r, pipe_idx_nxt;
  logic [COUNT_W-1:0] run_r, run_nxt;
  logic               res_found_r, res_found_nxt;
  logic [START_W-1:0] res_start_r, res_start_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [START_W-1:0] out_gap_start_r, out_gap_start_nxt;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [7:0]         ram_rdata;

  logic [7:0]         in_rng;
  logic [COUNT_W-1:0] run_v;
  logic               hit;
  bit_idx_t           hit_start;

  logic [BIT_W:0]     mark_sum;
  bit_idx_t           mark_hi;
  bit_idx_t           mark_hi_m1;
  logic [MAPB_W-1:0]  find_bytes;
  logic [BIT_W:0]     find_lim;
  bit_idx_t           find_hi;
  bit_idx_t           find_hi_m1;
  logic               cfg_wr;
  logic               out_load;

  bga_ram #(
    .WIDTH (8),
    .DEPTH (MapBytes),
    .AW    (AddrW)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (AddrW'(rd_idx_r)),
    .rd_data (ram_rdata)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MAP_BYTES: cfg_prdata = CFG_DATA_W'(map_bytes_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_bytes_r <= MAP_BYTES_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_MAP_BYTES)) begin
      map_bytes_r <= cfg_pwdata[MAPB_W-1:0];
    end
  end

  // Range bounds for a new beat.
  always_comb begin
    mark_sum   = (BIT_W+1)'(in_offset) + (BIT_W+1)'(in_count);
    mark_hi    = (mark_sum > BitCap) ? BitCap[BIT_W-1:0] : mark_sum[BIT_W-1:0];
    mark_hi_m1 = mark_hi - 1'b1;
    find_bytes = (map_bytes_r > BytesCap) ? BytesCap : map_bytes_r;
    find_lim   = {1'b0, find_bytes, 3'b000};
    find_hi    = (find_lim > BitCap) ? BitCap[BIT_W-1:0] : find_lim[BIT_W-1:0];
    find_hi_m1 = find_hi - 1'b1;
  end

  // Evaluation of the byte that the RAM returns this cycle.
  always_comb begin
    bit_idx_t bit_b;
    run_v     = run_r;
    hit       = 1'b0;
    hit_start = '0;
    in_rng    = '0;
    for (int j = 0; j < 8; j++) begin
      bit_b     = {pipe_idx_r, 3'(j)};
      in_rng[j] = (bit_b >= lo_r) && (bit_b < hi_r);
      if (!hit) begin
        if (ram_rdata[j] || !in_rng[j]) begin
          run_v = '0;
        end else begin
          run_v = run_v + 1'b1;
          if (run_v == count_r) begin
            hit       = 1'b1;
            hit_start = bit_b + 1'b1 - count_r;
          end
        end
      end
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt         = state_r;
    clr_idx_nxt       = clr_idx_r;
    act_nxt           = act_r;
    count_nxt         = count_r;
    lo_nxt            = lo_r;
    hi_nxt            = hi_r;
    rd_idx_nxt        = rd_idx_r;
    last_idx_nxt      = last_idx_r;
    rd_more_nxt       = rd_more_r;
    pipe_vld_nxt      = 1'b0;
    pipe_idx_nxt      = pipe_idx_r;
    run_nxt           = run_r;
    res_found_nxt     = res_found_r;
    res_start_nxt     = res_start_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_found_nxt     = out_found_r;
    out_gap_start_nxt = out_gap_start_r;
    ram_we            = 1'b0;
    ram_waddr         = AddrW'(pipe_idx_r);
    ram_wdata         = '0;
    ram_re            = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == ClrLast) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt       = in_action;
          count_nxt     = in_count;
          run_nxt       = '0;
          res_found_nxt = 1'b0;
          res_start_nxt = '0;
          rd_more_nxt   = 1'b1;
          state_nxt     = ST_DONE;
          case (in_action) inside
            ACT_FIND: begin
              lo_nxt       = '0;
              hi_nxt       = find_hi;
              rd_idx_nxt   = '0;
              last_idx_nxt = find_hi_m1[BIT_W-1:3];
              if (find_bytes == '0) begin
                res_found_nxt = 1'b0;
              end else if (in_count == '0) begin
                res_found_nxt = 1'b1;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            ACT_MARK, ACT_UNMARK: begin
              lo_nxt       = bit_idx_t'(in_offset);
              hi_nxt       = mark_hi;
              rd_idx_nxt   = byte_idx_t'(in_offset[OFFSET_W-1:3]);
              last_idx_nxt = mark_hi_m1[BIT_W-1:3];
              if (mark_hi > bit_idx_t'(in_offset)) begin
                state_nxt = ST_WALK;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_WALK: begin
        ram_re = rd_more_r;
        if (rd_more_r) begin
          rd_idx_nxt   = rd_idx_r + 1'b1;
          rd_more_nxt  = (rd_idx_r != last_idx_r);
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = rd_idx_r;
        end
        if (pipe_vld_r) begin
          if (act_r == ACT_FIND) begin
            run_nxt = run_v;
            if (hit) begin
              res_found_nxt = 1'b1;
              res_start_nxt = hit_start[START_W-1:0];
            end
            if (hit || (pipe_idx_r == last_idx_r)) begin
              state_nxt    = ST_DONE;
              rd_more_nxt  = 1'b0;
              pipe_vld_nxt = 1'b0;
            end
          end else begin
            ram_we    = 1'b1;
            ram_wdata = (act_r == ACT_MARK) ? (ram_rdata | in_rng) : (ram_rdata & ~in_rng);
            if (pipe_idx_r == last_idx_r) begin
              state_nxt    = ST_DONE;
              rd_more_nxt  = 1'b0;
              pipe_vld_nxt = 1'b0;
            end
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt     = 1'b1;
          out_found_nxt     = res_found_r;
          out_gap_start_nxt = res_start_r;
          state_nxt         = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      rd_more_r   <= 1'b0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      rd_more_r   <= rd_more_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r           <= act_nxt;
    count_r         <= count_nxt;
    lo_r            <= lo_nxt;
    hi_r            <= hi_nxt;
    rd_idx_r        <= rd_idx_nxt;
    last_idx_r      <= last_idx_nxt;
    pipe_idx_r      <= pipe_idx_nxt;
    run_r           <= run_nxt;
    res_found_r     <= res_found_nxt;
    res_start_r     <= res_start_nxt;
    out_found_r     <= out_found_nxt;
    out_gap_start_r <= out_gap_start_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_gap_start = out_gap_start_r;

`include "bitmap_gap_allocator_assert.svh"

  `BGA_ASSERT_NEXT(a_done_loads_out, out_load, out_valid_r, "result not presented after done")
  `BGA_ASSERT_IMPLY(a_rose_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE, "result without done")
  `BGA_ASSERT_IMPLY(a_pipe_in_range, pipe_vld_r, pipe_idx_r <= last_idx_r, "byte past range end")
  `BGA_ASSERT_IMPLY(a_find_no_write, (state_r == ST_WALK) && ram_we, act_r != ACT_FIND, "find wrote the map")

endmodule
